// ===== src/b64u_pkg.sv =====
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types and constants for the strict base64url decoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

   // Command codes carried with each input transaction.
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Characters with special meaning.
   localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
   localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_UNDER = 8'h5F;  // '_'
   localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
   localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_D0    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_D9    = 8'h39;  // '9'

   // Sextet offsets of the alphabet ranges.
   localparam logic [5:0] SEXTET_LC_BASE = 6'd26;
   localparam logic [5:0] SEXTET_D_BASE  = 6'd52;
   localparam logic [5:0] SEXTET_DASH    = 6'd62;
   localparam logic [5:0] SEXTET_UNDER   = 6'd63;

   // Pads allowed in one message.
   localparam logic [1:0] PAD_MAX = 2'd2;

   typedef struct packed {
      logic [1:0] group_pos;
      logic [5:0] prev_sextet;
      logic [1:0] pad_count;
      logic       error_flag;
   } state_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] data_out;
      logic       malformed;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] sextet;
   } sextet_type;

endpackage

// ===== src/b64u_char_map.sv =====
// ----------------------------------------------------------------------------
// b64u_char_map
// Maps one character of the URL-safe alphabet to its 6-bit value.
// ----------------------------------------------------------------------------
module b64u_char_map (
   input  logic [7:0]          char_in,
   output b64u_pkg::sextet_type sextet
);

   logic [7:0] diff;

   always_comb begin
      diff   = 8'd0;
      sextet = '0;
      if (char_in >= b64u_pkg::CHAR_UC_A && char_in <= b64u_pkg::CHAR_UC_Z) begin
         diff          = char_in - b64u_pkg::CHAR_UC_A;
         sextet.valid  = 1'b1;
         sextet.sextet = diff[5:0];
      end else if (char_in >= b64u_pkg::CHAR_LC_A && char_in <= b64u_pkg::CHAR_LC_Z) begin
         diff          = char_in - b64u_pkg::CHAR_LC_A;
         sextet.valid  = 1'b1;
         sextet.sextet = diff[5:0] + b64u_pkg::SEXTET_LC_BASE;
      end else if (char_in >= b64u_pkg::CHAR_D0 && char_in <= b64u_pkg::CHAR_D9) begin
         diff          = char_in - b64u_pkg::CHAR_D0;
         sextet.valid  = 1'b1;
         sextet.sextet = diff[5:0] + b64u_pkg::SEXTET_D_BASE;
      end else if (char_in == b64u_pkg::CHAR_DASH) begin
         sextet.valid  = 1'b1;
         sextet.sextet = b64u_pkg::SEXTET_DASH;
      end else if (char_in == b64u_pkg::CHAR_UNDER) begin
         sextet.valid  = 1'b1;
         sextet.sextet = b64u_pkg::SEXTET_UNDER;
      end
   end

endmodule

// ===== src/b64u_step.sv =====
// ----------------------------------------------------------------------------
// b64u_step
// Next-state and result logic for one registered transaction.
// ----------------------------------------------------------------------------
module b64u_step (
   input  b64u_pkg::state_type  state,
   input  logic                 command,
   input  logic [7:0]           char_in,
   output b64u_pkg::state_type  state_next,
   output logic                 emit,
   output b64u_pkg::result_type result
);

   b64u_pkg::sextet_type sx;
   logic [2:0]           pad_sum;
   logic                 bad;

   b64u_char_map u_char_map (
      .char_in (char_in),
      .sextet  (sx)
   );

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      result     = '0;
      pad_sum    = {1'b0, state.pad_count} + {1'b0, state.group_pos};
      bad        = 1'b0;

      if (command == b64u_pkg::CMD_END) begin
         bad = state.error_flag
               || (state.group_pos == 2'd1)
               || ((state.pad_count != 2'd0)
                   && ((state.group_pos == 2'd0) || (pad_sum != 3'd4)))
               || ((state.group_pos == 2'd2) && (state.prev_sextet[3:0] != 4'd0))
               || ((state.group_pos == 2'd3) && (state.prev_sextet[1:0] != 2'd0));
         emit             = 1'b1;
         result.is_status = 1'b1;
         result.malformed = bad;
         state_next       = '0;
      end else if (char_in == b64u_pkg::CHAR_PAD) begin
         if (state.pad_count >= b64u_pkg::PAD_MAX) begin
            state_next.error_flag = 1'b1;
         end else begin
            state_next.pad_count = state.pad_count + 2'd1;
         end
      end else if (!sx.valid || (state.pad_count != 2'd0)) begin
         // Unknown character, or payload after a pad.
         state_next.error_flag = 1'b1;
      end else begin
         case (state.group_pos)
            2'd1: result.data_out = {state.prev_sextet, sx.sextet[5:4]};
            2'd2: result.data_out = {state.prev_sextet[3:0], sx.sextet[5:2]};
            2'd3: result.data_out = {state.prev_sextet[1:0], sx.sextet};
            default: result.data_out = 8'd0;
         endcase
         emit                   = (state.group_pos != 2'd0);
         state_next.prev_sextet = sx.sextet;
         state_next.group_pos   = state.group_pos + 2'd1;
      end
   end

endmodule

// ===== src/base64url_strict_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64url_strict_decoder_unit
// Streaming strict base64url decoder with an end-of-message status.
// ----------------------------------------------------------------------------
// One character or end mark is taken per clock while req_ready is high; a
// transaction enters an input register, is decoded from there against the
// group state, and its result (if any) lands in the output register. The only
// loop is the small group state updated at most once per cycle, which sets the
// rate of one transaction per cycle while the result side keeps taking results.
// Data bytes are emitted as decoded; the status result at the end mark reports
// whether the message was malformed, and the consumer discards bytes then.
// ----------------------------------------------------------------------------
module base64url_strict_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_status,
   output logic [7:0] rsp_data_out,
   output logic       rsp_malformed
);

   logic                 in_valid_ff, in_valid_in;
   logic                 in_command_ff, in_command_in;
   logic [7:0]           in_char_ff, in_char_in;
   b64u_pkg::state_type  state_ff, state_in;
   logic                 out_valid_ff, out_valid_in;
   b64u_pkg::result_type out_ff, out_in;

   b64u_pkg::state_type  state_next;
   logic                 emit;
   b64u_pkg::result_type result;
   logic                 advance;
   logic                 fire;

   b64u_step u_step (
      .state      (state_ff),
      .command    (in_command_ff),
      .char_in    (in_char_ff),
      .state_next (state_next),
      .emit       (emit),
      .result     (result)
   );

   // The decode stage moves whenever the output register is free or draining.
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_command_in = in_command_ff;
      in_char_in    = in_char_ff;
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (advance) begin
         out_valid_in = fire && emit;
         out_in       = result;
      end
      if (fire) begin
         state_in = state_next;
      end
      if (req_ready) begin
         in_valid_in   = req_valid;
         in_command_in = req_command;
         in_char_in    = req_char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_command_ff <= in_command_in;
      in_char_ff    <= in_char_in;
      out_ff        <= out_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_is_status = out_ff.is_status;
   assign rsp_data_out  = out_ff.data_out;
   assign rsp_malformed = out_ff.malformed;

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_status) |-> (rsp_data_out == 8'd0))
      else $error("status result carries nonzero data");

   a_data_not_malformed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_status) |-> !rsp_malformed)
      else $error("data result flagged malformed");

   a_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      (fire && in_command_ff == b64u_pkg::CMD_END) |=> (state_ff == '0))
      else $error("state not cleared after end of message");

   a_pad_saturates: assert property (@(posedge clock) disable iff (reset)
      state_ff.pad_count != 2'd3)
      else $error("pad count beyond two");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

endmodule
